// ----- rtl/core/ujbu_pkg.sv -----
// Package for the u-law jitter buffer: sizes, codes, shared structs
// and the u-law expander. No dependencies.
package ujbu_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int LEVEL_W    = 13;
  localparam int CMP_W      = (FILL_W > LEVEL_W) ? FILL_W : LEVEL_W;
  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int PCM_W      = 16;
  localparam int DROP_W     = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(2400);

  localparam logic [7:0]  ULAW_BIAS = 8'h84;
  localparam logic [7:0]  ULAW_MANT = 8'h0F;
  localparam logic [7:0]  ULAW_SEG  = 8'h70;
  localparam logic [7:0]  ULAW_SIGN = 8'h80;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_PULL  = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_AUDIO = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              accepted;
    logic              playing;
    logic [DROP_W-1:0] dropped;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  // ITU u-law expansion to 16-bit linear PCM
  function automatic logic signed [PCM_W-1:0] ulaw_expand(input logic [BYTE_W-1:0] code);
    logic [7:0]        u;
    logic [PCM_W-1:0]  mag;
    logic [PCM_W-1:0]  bias;
    u    = ~code;
    bias = PCM_W'(ULAW_BIAS);
    mag  = PCM_W'({1'b0, u & ULAW_MANT, 3'b000}) + bias;
    mag  = mag << ((u & ULAW_SEG) >> 4);
    if ((u & ULAW_SIGN) != 8'h00) begin
      ulaw_expand = signed'(bias - mag);
    end else begin
      ulaw_expand = signed'(mag - bias);
    end
  endfunction

endpackage

// ----- rtl/core/ujbu_if.sv -----
// Channel interfaces of the u-law jitter buffer: request, result and
// configuration. Depends on ujbu_pkg.
interface ujbu_req_if;
  logic                          valid;
  logic                          ready;
  logic [ujbu_pkg::MODE_W-1:0]   mode;
  logic [ujbu_pkg::BYTE_W-1:0]   push_byte;
  modport source (output valid, output mode, output push_byte, input ready);
  modport sink (input valid, input mode, input push_byte, output ready);
endinterface

interface ujbu_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ujbu_pkg::PCM_W-1:0]  pcm_sample;
  logic                               sample_valid;
  logic                               last;
  logic                               accepted;
  logic                               playing;
  logic [ujbu_pkg::DROP_W-1:0]        dropped_total;
  modport source (output valid, output pcm_sample, output sample_valid, output last,
                  output accepted, output playing, output dropped_total, input ready);
  modport sink (input valid, input pcm_sample, input sample_valid, input last,
                input accepted, input playing, input dropped_total, output ready);
endinterface

interface ujbu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ujbu_pkg::LEVEL_W-1:0]  prebuffer_level;
  modport source (output valid, output prebuffer_level, input ready);
  modport sink (input valid, input prebuffer_level, output ready);
endinterface

// ----- rtl/core/ujbu_ring_ram.sv -----
// Ring storage: one write port, one read port, registered read data.
// Depends on ujbu_pkg.
module ujbu_ring_ram (
  input  logic                        clk_i,
  input  ujbu_pkg::ram_req_t          req_i,
  output logic [ujbu_pkg::BYTE_W-1:0] rdata_o
);
  import ujbu_pkg::*;

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ujbu_ctrl.sv -----
// Buffer control: pointers, fill, playback flag, drop counter and the
// prebuffer level; issues ring accesses. Depends on ujbu_pkg, ujbu_if.
module ujbu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  ujbu_req_if.sink           req_i,
  ujbu_cfg_if.sink           cfg_i,
  input  logic               load_ok_i,
  output ujbu_pkg::ram_req_t ram_req_o,
  output logic               item_valid_o,
  output ujbu_pkg::item_t    item_o
);
  import ujbu_pkg::*;

  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rp_q, rp_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               play_q, play_d;
  logic [DROP_W-1:0]  drop_q, drop_d;
  logic [LEVEL_W-1:0] level_q;
  logic               s1_valid_q;
  item_t              item_q, item_d;
  logic               accept;
  logic               full;
  logic               level_met;

  assign req_i.ready = !s1_valid_q || load_ok_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (fill_q == FILL_W'(RING_DEPTH));
  assign level_met   = CMP_W'(fill_q) >= CMP_W'(level_q);

  always_comb begin
    wp_d             = wp_q;
    rp_d             = rp_q;
    fill_d           = fill_q;
    play_d           = play_q;
    drop_d           = drop_q;
    item_d.kind      = KIND_PLAIN;
    item_d.accepted  = 1'b0;
    ram_req_o.we     = 1'b0;
    ram_req_o.waddr  = wp_q;
    ram_req_o.wdata  = req_i.push_byte;
    ram_req_o.re     = 1'b0;
    ram_req_o.raddr  = rp_q;
    case (req_i.mode)
      MODE_PUSH: begin
        if (full) begin
          // saturate
          if (drop_q != '1) begin
            drop_d = drop_q + DROP_W'(1);
          end
        end else begin
          ram_req_o.we    = accept;
          wp_d            = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
          fill_d          = fill_q + FILL_W'(1);
          item_d.accepted = 1'b1;
        end
      end
      MODE_PULL: begin
        if (play_q || level_met) begin
          if (fill_q == '0) begin
            play_d = 1'b0;
          end else begin
            ram_req_o.re = accept;
            rp_d         = (rp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
            fill_d       = fill_q - FILL_W'(1);
            play_d       = 1'b1;
            item_d.kind  = KIND_AUDIO;
          end
        end
      end
      MODE_FLUSH: begin
        wp_d        = '0;
        rp_d        = '0;
        fill_d      = '0;
        play_d      = 1'b0;
        item_d.kind = KIND_FLUSH;
      end
      default: begin
      end
    endcase
    item_d.playing = play_d;
    item_d.dropped = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      fill_q     <= '0;
      play_q     <= 1'b0;
      drop_q     <= '0;
      level_q    <= LEVEL_RESET;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        level_q <= cfg_i.prebuffer_level;
      end
      if (accept) begin
        wp_q       <= wp_d;
        rp_q       <= rp_d;
        fill_q     <= fill_d;
        play_q     <= play_d;
        drop_q     <= drop_d;
        s1_valid_q <= 1'b1;
      end else if (load_ok_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = s1_valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/core/ujbu_out.sv -----
// Result stage: expands the popped byte, forms the midpoint with the
// previous sample and serializes the results. Depends on ujbu_pkg, ujbu_if.
module ujbu_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  ujbu_pkg::item_t             item_i,
  input  logic [ujbu_pkg::BYTE_W-1:0] rdata_i,
  output logic                        load_ok_o,
  ujbu_rsp_if.source                  rsp_o
);
  import ujbu_pkg::*;

  logic                    s2_valid_q;
  logic                    s2_first_q;
  item_t                   s2_item_q;
  logic signed [PCM_W-1:0] mid_q;
  logic signed [PCM_W-1:0] cur_q;
  logic signed [PCM_W-1:0] prev_q;
  logic signed [PCM_W-1:0] cur_w;
  logic signed [PCM_W:0]   sum_w;
  logic                    is_audio;
  logic                    emit_last;
  logic                    done;
  logic                    load;

  assign cur_w     = ulaw_expand(rdata_i);
  assign sum_w     = (PCM_W + 1)'(prev_q) + (PCM_W + 1)'(cur_w);
  assign is_audio  = (s2_item_q.kind == KIND_AUDIO);
  assign emit_last = !is_audio || !s2_first_q;
  assign done      = s2_valid_q && rsp_o.ready && emit_last;
  assign load_ok_o = !s2_valid_q || done;
  assign load      = item_valid_i && load_ok_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      prev_q     <= '0;
    end else begin
      if (load) begin
        s2_valid_q <= 1'b1;
        s2_first_q <= 1'b1;
        if (item_i.kind == KIND_AUDIO) begin
          prev_q <= cur_w;
        end else if (item_i.kind == KIND_FLUSH) begin
          prev_q <= '0;
        end
      end else if (done) begin
        s2_valid_q <= 1'b0;
      end else if (s2_valid_q && rsp_o.ready) begin
        // midpoint taken, advance to the sample itself
        s2_first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_item_q <= item_i;
      mid_q     <= sum_w[PCM_W:1];
      cur_q     <= cur_w;
    end
  end

  assign rsp_o.valid         = s2_valid_q;
  assign rsp_o.pcm_sample    = !is_audio ? '0 : (s2_first_q ? mid_q : cur_q);
  assign rsp_o.sample_valid  = is_audio;
  assign rsp_o.last          = emit_last;
  assign rsp_o.accepted      = s2_item_q.accepted;
  assign rsp_o.playing       = s2_item_q.playing;
  assign rsp_o.dropped_total = s2_item_q.dropped;

endmodule

// ----- rtl/core/ulaw_jitter_buffer_upsampler_top.sv -----
// Top level of the u-law playout jitter buffer with 2x upsampling.
// Depends on ujbu_pkg, ujbu_if, ujbu_ring_ram, ujbu_ctrl, ujbu_out.
//
// Channels: req_i carries requests (mode push, pull or flush, and the
// u-law byte for a push); rsp_o carries results; cfg_i writes the
// prebuffer level, accepted in any cycle (ready is tied high).
// A push, flush, idle-mode or non-playing pull request gives one result;
// a pull that plays a byte gives two (midpoint, then the decoded sample,
// last on the second). Results pass the control stage register, then the
// result register. Throughput: one request per cycle for single-result
// requests while the receiver does not stall; a playing pull holds the
// single result port for both its results. The ring is read at the pull's
// acceptance edge; its byte is expanded as the next request enters.
// A pull that follows a push to the same entry reads the new byte because
// the ring is written at the push's acceptance edge.
// Reset clears pointers, fill, playback flag, previous sample and drop
// counter and loads the prebuffer level with 2400; no clearing pass runs.
// When the receiver stalls, the result register and one stage behind it
// hold their requests, then req_i.ready drops.
module ulaw_jitter_buffer_upsampler_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  ujbu_req_if.sink req_i,
  ujbu_cfg_if.sink cfg_i,
  ujbu_rsp_if.source rsp_o
);
  import ujbu_pkg::*;

  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rdata;
  logic              item_valid;
  item_t             item;
  logic              load_ok;

  ujbu_ring_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  ujbu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_i),
    .load_ok_i    (load_ok),
    .ram_req_o    (ram_req),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ujbu_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .rdata_i      (ram_rdata),
    .load_ok_o    (load_ok),
    .rsp_o        (rsp_o)
  );

  // audio is only produced while playing
  a_audio_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.sample_valid |-> rsp_o.playing)
    else $error("audio result while not playing");

  // a taken midpoint is followed by its decoded sample
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && rsp_o.sample_valid && !rsp_o.last |=>
    rsp_o.valid && rsp_o.sample_valid && rsp_o.last)
    else $error("midpoint not followed by its sample");

  // stalled requests only when the internal stage is occupied
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> item_valid && !load_ok)
    else $error("request stalled with free stage");

  // ring is never read and written in the same cycle
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("ring read and write in one cycle");

endmodule
